### rtl/srtet_pkg.sv
// shared types and constants of the sonar round-robin trigger and echo timer
package srtet_pkg;

  localparam int unsigned ChannelsDefault = 8;
  localparam int unsigned ChanW           = 3;
  localparam int unsigned TicksW          = 16;
  localparam int unsigned TableW          = 64;
  localparam int unsigned CodeW           = 8;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [TicksW-1:0] ComparePeriodReset = 16'd1562;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_TABLE   = 2'd0,
    REG_HIGHEST_CHANNEL = 2'd1,
    REG_COMPARE_PERIOD  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACTION_TICK = 1'b0,
    ACTION_ECHO = 1'b1
  } action_e;

  typedef struct packed {
    logic action;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic              trigger_pulse;
    logic [2:0]        trigger_port;
    logic [2:0]        trigger_pin;
    logic [ChanW-1:0]  active_channel;
    logic              measure_valid;
    logic [TicksW-1:0] measure_ticks;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [TableW-1:0]  data;
  } cfg_item_t;

endpackage

### rtl/srtet_stream_if.sv
// valid/ready channel carrying one item of a given payload type
interface srtet_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sonar_round_robin_trigger_echo_timer_unit.sv
// top level of the sonar round-robin trigger and echo timer
// Each input item is a timer tick or an echo pin change, and each gives exactly one result
// item. An item is taken into an input register, and its result then moves into the output
// register together with the updated tick counter, channel and echo start once the output
// slot is free or being taken. A new item is accepted every cycle unless the block holds
// off its input, which it does only when both registers are full and the result is not
// taken. On a tick equal to compare_period the counter clears and the
// rotation moves to the next channel (wrapping after the smaller of highest_channel and
// CHANNELS-1), and a trigger is reported with that channel's port and pin unless its port
// code is zero. A rising echo latches the counter; a falling echo reports the 16-bit
// modular difference. Configuration writes are always accepted and must come only while
// no item is in flight; writing compare_period also clears the counter.
module sonar_round_robin_trigger_echo_timer_unit
  import srtet_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  srtet_stream_if.sink   in_i,
  srtet_stream_if.source out_o,
  srtet_stream_if.sink   cfg_i
);

  // last channel the table can hold for this build
  localparam logic [ChanW-1:0] TopChan = ChanW'(CHANNELS - 1);

  // configuration registers
  logic [TableW-1:0] channel_table_q;
  logic [ChanW-1:0]  highest_channel_q;
  logic [TicksW-1:0] compare_period_q;

  // block state
  logic [TicksW-1:0] tick_count_q, tick_count_d;
  logic [ChanW-1:0]  current_channel_q, current_channel_d;
  logic [TicksW-1:0] echo_start_q, echo_start_d;

  // input register stage
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // output register stage
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic s2_go;
  logic s1_take;
  logic cfg_we;

  logic [ChanW-1:0] limit;
  logic [CodeW-1:0] code;

  // result stage moves when the output slot is free or being taken
  assign s2_go   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_go;
  assign s1_take = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // rotation bound: smaller of register and build limit
  assign limit = (TopChan < highest_channel_q) ? TopChan : highest_channel_q;

  always_comb begin
    tick_count_d      = tick_count_q;
    current_channel_d = current_channel_q;
    echo_start_d      = echo_start_q;
    code              = '0;
    out_item_d        = '0;

    if (s1_item_q.action == ACTION_TICK) begin
      if (tick_count_q == compare_period_q) begin
        tick_count_d = '0;
        // wrap also covers a channel left above a lowered bound
        if (current_channel_q >= limit) begin
          current_channel_d = '0;
        end else begin
          current_channel_d = current_channel_q + ChanW'(1);
        end
        code = channel_table_q[current_channel_d*CodeW +: CodeW];
        // port code zero selects the channel with no trigger
        if (code[6:4] != 3'd0) begin
          out_item_d.trigger_pulse = 1'b1;
          out_item_d.trigger_port  = code[6:4];
          out_item_d.trigger_pin   = code[2:0];
        end
      end else begin
        tick_count_d = tick_count_q + TicksW'(1);
      end
    end else if (s1_item_q.echo_level) begin
      echo_start_d = tick_count_q;
    end else begin
      out_item_d.measure_valid = 1'b1;
      out_item_d.measure_ticks = tick_count_q - echo_start_q;
    end

    out_item_d.active_channel = current_channel_d;
  end

  // configuration and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_table_q   <= '0;
      highest_channel_q <= '0;
      compare_period_q  <= ComparePeriodReset;
      tick_count_q      <= '0;
      current_channel_q <= '0;
      echo_start_q      <= '0;
    end else begin
      if (s1_valid_q && s2_go) begin
        tick_count_q      <= tick_count_d;
        current_channel_q <= current_channel_d;
        echo_start_q      <= echo_start_d;
      end
      if (cfg_we) begin
        unique case (cfg_i.data.index)
          REG_CHANNEL_TABLE: begin
            channel_table_q <= cfg_i.data.data;
          end
          REG_HIGHEST_CHANNEL: begin
            highest_channel_q <= cfg_i.data.data[ChanW-1:0];
          end
          REG_COMPARE_PERIOD: begin
            compare_period_q <= cfg_i.data.data[TicksW-1:0];
            tick_count_q     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_go) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_item_q <= in_i.data;
    end
    if (s1_valid_q && s2_go) begin
      out_item_q <= out_item_d;
    end
  end

`ifndef ASSERT_OFF
  // a result never carries both a trigger and a measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.trigger_pulse && out_item_q.measure_valid))
    else $error("trigger and measurement in one item");

  // a reported trigger always names a real port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.trigger_pulse) |-> (out_item_q.trigger_port != 3'd0))
    else $error("trigger with port code zero");

  // an item in the input register moves to the output when the slot frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_go) |=> out_valid_q)
    else $error("item lost between stages");

  // a trigger comes only with a counter that just cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_go && out_item_d.trigger_pulse && !cfg_we) |=> (tick_count_q == '0))
    else $error("trigger without counter clear");
`endif

endmodule

### sim/tb.sv
// testbench of the sonar round-robin trigger and echo timer: predicted reports checked item by item
`timescale 1ns / 1ps

module tb;
  import srtet_pkg::*;

  localparam int unsigned NumChannels = ChannelsDefault;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned LongHold    = 300;
  // index past the last register, the block must drop such a write
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk;
  logic rst_n;

  srtet_stream_if #(.payload_t(in_item_t))  in_if ();
  srtet_stream_if #(.payload_t(out_item_t)) out_if ();
  srtet_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  sonar_round_robin_trigger_echo_timer_unit #(
    .CHANNELS(NumChannels)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // tick and echo events waiting to be offered, and the reports they must produce
  in_item_t  pending_events[$];
  out_item_t predicted_reports[$];

  // mirror of the block's registers and state
  logic [TableW-1:0] chan_table;
  logic [ChanW-1:0]  top_chan;
  logic [TicksW-1:0] slot_period;
  logic [TicksW-1:0] tick_cnt;
  logic [ChanW-1:0]  cur_chan;
  logic [TicksW-1:0] echo_mark;

  // knobs driven by the sequence
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_start;

  // long hold-off state of the receiver
  int unsigned hold_left;
  logic        hold_used;

  // bookkeeping
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned echo_events;
  int unsigned reports_seen;
  int unsigned pulses_seen;
  int unsigned widths_seen;
  int unsigned reg_writes;
  int unsigned quiet_cycles;
  logic [NumChannels-1:0] chans_pulsed;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // next state of the sonar for one event, returns the report it must give
  function automatic out_item_t predict_sonar_report(in_item_t ev);
    out_item_t rep;
    logic [7:0] code;
    logic [ChanW-1:0] bound;
    rep = '0;
    // rotation wraps after the smaller of highest_channel and the last channel (count minus one)
    bound = (top_chan < NumChannels - 1) ? top_chan : ChanW'(NumChannels - 1);
    if (ev.action == ACTION_TICK) begin
      if (tick_cnt == slot_period) begin
        // slot over: clear the counter and move on to the next sonar
        tick_cnt = '0;
        cur_chan = (cur_chan >= bound) ? '0 : cur_chan + 1'b1;
        code = chan_table[cur_chan*8 +: 8];
        // port code zero selects the channel but fires nothing
        if (code[6:4] != 3'd0) begin
          rep.trigger_pulse = 1'b1;
          rep.trigger_port  = code[6:4];
          rep.trigger_pin   = code[2:0];
        end
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else if (ev.echo_level) begin
      echo_mark = tick_cnt;
    end else begin
      // falling edge: width is the modular distance from the rising edge
      rep.measure_valid = 1'b1;
      rep.measure_ticks = tick_cnt - echo_mark;
    end
    rep.active_channel = cur_chan;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [TicksW-1:0] want,
                                      logic [TicksW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_event(action_e act, logic level);
    in_item_t ev;
    ev.action     = act;
    ev.echo_level = level;
    pending_events.push_back(ev);
  endfunction

  // driver: offer the next event, with random idle gaps, when the channel is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_events.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver side: random stalls, plus one long hold-off counted down here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
    end else if (hold_start && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LongHold;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: mirror register writes, predict on every accepted event, check every report
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      chan_table   = '0;
      top_chan     = '0;
      slot_period  = ComparePeriodReset;
      tick_cnt     = '0;
      cur_chan     = '0;
      echo_mark    = '0;
      mismatches   = 0;
      events_sent  = 0;
      echo_events  = 0;
      reports_seen = 0;
      pulses_seen  = 0;
      widths_seen  = 0;
      reg_writes   = 0;
      chans_pulsed = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        case (cfg_if.data.index)
          REG_CHANNEL_TABLE:   chan_table = cfg_if.data.data;
          REG_HIGHEST_CHANNEL: top_chan = cfg_if.data.data[ChanW-1:0];
          REG_COMPARE_PERIOD: begin
            // a new compare value restarts the slot
            slot_period = cfg_if.data.data[TicksW-1:0];
            tick_cnt    = '0;
          end
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        events_sent++;
        if (in_if.data.action == ACTION_ECHO) echo_events++;
        predicted_reports.push_back(predict_sonar_report(in_if.data));
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        reports_seen++;
        if (predicted_reports.size() == 0) begin
          $error("report with no event pending: %p", got);
          mismatches++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("trigger_pulse", TicksW'(want.trigger_pulse),
                      TicksW'(got.trigger_pulse));
          check_field("trigger_port", TicksW'(want.trigger_port),
                      TicksW'(got.trigger_port));
          check_field("trigger_pin", TicksW'(want.trigger_pin), TicksW'(got.trigger_pin));
          check_field("active_channel", TicksW'(want.active_channel),
                      TicksW'(got.active_channel));
          check_field("measure_valid", TicksW'(want.measure_valid),
                      TicksW'(got.measure_valid));
          check_field("measure_ticks", want.measure_ticks, got.measure_ticks);
          if (want.trigger_pulse) begin
            pulses_seen++;
            chans_pulsed[want.active_channel] = 1'b1;
          end
          if (want.measure_valid) widths_seen++;
        end
      end
    end
  end

  // watchdog: give up after a long stretch with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 quiet_cycles, predicted_reports.size());
        $display("FAIL sonar_round_robin_trigger_echo_timer_unit");
        $finish;
      end
    end
  end

  // one register write, with valid dropped again before returning
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TableW-1:0] value);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // block idle: nothing queued or offered and every report back
  task automatic wait_quiet();
    while (pending_events.size() != 0 || in_if.valid || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed echo pulses between runs of ticks, with some stray events
  task automatic queue_random(int unsigned count);
    int unsigned target;
    int unsigned gap;
    target = pending_events.size() + count;
    while (pending_events.size() < target) begin
      case ($urandom_range(9))
        0: push_event(action_e'($urandom_range(1)), 1'($urandom_range(1)));
        1, 2, 3: begin
          push_event(ACTION_ECHO, 1'b1);
          gap = $urandom_range(12);
          repeat (gap) push_event(ACTION_TICK, 1'($urandom_range(1)));
          push_event(ACTION_ECHO, 1'b0);
        end
        default: begin
          gap = $urandom_range(1, 8);
          repeat (gap) push_event(ACTION_TICK, 1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start     = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // directed: mixed port codes (zero ports, stray bits 7 and 3), full rotation, period 1
    write_reg(REG_CHANNEL_TABLE, 64'hF7_10_8F_35_07_71_08_FF);
    write_reg(REG_HIGHEST_CHANNEL, 64'd7);
    write_reg(REG_COMPARE_PERIOD, 64'd1);
    push_event(ACTION_ECHO, 1'b0);   // fall with nothing latched: zero width
    push_event(ACTION_ECHO, 1'b1);
    push_event(ACTION_TICK, 1'b1);
    push_event(ACTION_ECHO, 1'b1);   // latch at count 1
    push_event(ACTION_TICK, 1'b0);   // slot change clears the counter
    push_event(ACTION_ECHO, 1'b0);   // width wraps to all ones
    repeat (14) push_event(ACTION_TICK, 1'($urandom_range(1)));  // through channel 7 and back
    push_event(ACTION_ECHO, 1'b1);
    push_event(ACTION_TICK, 1'b0);
    push_event(ACTION_ECHO, 1'b0);
    wait_quiet();

    // unused index must change nothing, then compare value zero: every tick changes slot
    write_reg(RegUnused, '1);
    write_reg(REG_COMPARE_PERIOD, 64'd0);
    repeat (4) push_event(ACTION_TICK, 1'b0);
    push_event(ACTION_ECHO, 1'b0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_quiet();
      // per phase: free run, sender gaps, receiver stalls, both
      send_idle_pct  = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 27 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 27 : 0;
      case (ph)
        0: begin
          write_reg(REG_CHANNEL_TABLE, {$urandom, $urandom});
          write_reg(REG_HIGHEST_CHANNEL, 64'd7);
          write_reg(REG_COMPARE_PERIOD, 64'd3);
        end
        1: begin
          // shrinking the rotation below the current channel forces a wrap
          write_reg(REG_CHANNEL_TABLE, '1);
          write_reg(REG_HIGHEST_CHANNEL, 64'd0);
          write_reg(REG_COMPARE_PERIOD, 64'd0);
        end
        3: begin
          // no slot change can be reached with the widest compare value
          write_reg(REG_CHANNEL_TABLE, '0);
          write_reg(REG_HIGHEST_CHANNEL, 64'd3);
          write_reg(REG_COMPARE_PERIOD, 64'd65535);
        end
        default: begin
          write_reg(REG_CHANNEL_TABLE, {$urandom, $urandom});
          write_reg(REG_HIGHEST_CHANNEL, 64'($urandom_range(7)));
          write_reg(REG_COMPARE_PERIOD, 64'($urandom_range(12)));
        end
      endcase
      queue_random((ph == 3) ? 30 : 65);
      // long hold-off on the result side while events keep coming
      if (ph == 2) hold_start = 1'b1;
    end

    wait_quiet();
    repeat (8) @(posedge clk);

    $display("covered %0d events (%0d echo), %0d reports, %0d trigger pulses, %0d widths",
             events_sent, echo_events, reports_seen, pulses_seen, widths_seen);
    $display("%0d register writes, channels pulsed mask %b", reg_writes, chans_pulsed);
    if (mismatches == 0) begin
      $display("PASS sonar_round_robin_trigger_echo_timer_unit");
    end else begin
      $display("FAIL sonar_round_robin_trigger_echo_timer_unit");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/srtet_pkg.sv
rtl/srtet_stream_if.sv
rtl/sonar_round_robin_trigger_echo_timer_unit.sv
sim/tb.sv
